// ===== hdl/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// shared constants and controller/datapath interface types for the
// binary to decimal ascii converter
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    localparam int DEF_VALUE_BITS = 32;

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit;
    } t_bda_cmd;

    typedef struct packed {
        logic bit_done;
        logic top_zero;
        logic one_left;
    } t_bda_status;

endpackage

`default_nettype wire

// ===== hdl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// converts an unsigned binary value to ascii decimal digits, most
// significant first, leading zeros suppressed
// ----------------------------------------------------------------------------
//
//  channel   signals                          handshake
//  request   i_value                          start && !busy
//  digit     o_digit_char, o_last_digit       o_valid, one cycle each
//
//  busy is registered and stays high while a request is converted, so a new
//  request is taken only after busy drops. busy covers the shift-add-3 loop,
//  one input bit a cycle, and the digit scan, one decimal position a cycle
//  (skipped zero or emitted digit). digits of one request come out in
//  consecutive cycles, the last registered as busy drops. the digit sink
//  cannot stall.
//  reset is synchronous, active low, and clears the sequencer and strobe.
//
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = bda_pkg::DEF_VALUE_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire [VALUE_BITS-1:0] i_value,
    output logic                 o_valid,
    output logic [5:0]           o_digit_char,
    output logic                 o_last_digit
);
    import bda_pkg::*;

    // decimal digits needed for VALUE_BITS bits
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    t_bda_cmd    w_cmd;
    t_bda_status w_status;

    bda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    bda_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

`default_nettype wire

// ===== hdl/bda_ctrl.sv =====
// ----------------------------------------------------------------------------
// bda_ctrl
// sequencer: load, shift-add-3 conversion, leading zero skip, digit emit
// ----------------------------------------------------------------------------
`default_nettype none

module bda_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  bda_pkg::t_bda_status i_status,
    output bda_pkg::t_bda_cmd    o_cmd
);
    import bda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state   r_state, n_state;
    logic     r_busy, n_busy;
    t_bda_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                    n_busy     = 1'b1;
                end
            end
            ST_CONV: begin
                w_cmd.conv = 1'b1;
                if (i_status.bit_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_status.top_zero && !i_status.one_left) begin
                    w_cmd.skip = 1'b1;
                end else begin
                    w_cmd.emit = 1'b1;
                    if (i_status.one_left) begin
                        n_state = ST_IDLE;
                        n_busy  = 1'b0;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                w_cmd.emit = 1'b1;
                if (i_status.one_left) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy  = r_busy;
    assign o_cmd = w_cmd;

endmodule

`default_nettype wire

// ===== hdl/bda_datapath.sv =====
// ----------------------------------------------------------------------------
// bda_datapath
// binary shift register, bcd digit register with add-3 correction,
// counters and the registered character output
// ----------------------------------------------------------------------------
`default_nettype none

module bda_datapath #(
    parameter int VALUE_BITS = bda_pkg::DEF_VALUE_BITS,
    parameter int DIGITS     = 10
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [VALUE_BITS-1:0]  i_value,
    input  bda_pkg::t_bda_cmd     i_cmd,
    output bda_pkg::t_bda_status  o_status,
    output logic                  o_valid,
    output logic [5:0]            o_digit_char,
    output logic                  o_last_digit
);
    import bda_pkg::*;

    localparam int BCD_W  = DIGITS * 4;
    localparam int BIT_CW = $clog2(VALUE_BITS);
    localparam int DIG_CW = $clog2(DIGITS + 1);

    logic [VALUE_BITS-1:0] r_shift;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      w_adj;
    logic [BIT_CW-1:0]     r_bit;
    logic [DIG_CW-1:0]     r_cnt;
    logic [3:0]            w_top;
    logic                  r_valid;
    logic [5:0]            r_char;
    logic                  r_last;

    assign w_top = r_bcd[BCD_W-1 -: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_bit   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_shift <= i_value;
                r_bcd   <= '0;
                r_bit   <= '0;
                r_cnt   <= DIG_CW'(DIGITS);
            end
            if (i_cmd.conv) begin
                r_bcd   <= {w_adj[BCD_W-2:0], r_shift[VALUE_BITS-1]};
                r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
                r_bit   <= r_bit + 1'b1;
            end
            if (i_cmd.skip || i_cmd.emit) begin
                r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.emit) begin
                r_char <= ASCII_ZERO + {2'b00, w_top};
                r_last <= (r_cnt == DIG_CW'(1));
            end
        end
    end

    assign o_status.bit_done = (r_bit == BIT_CW'(VALUE_BITS - 1));
    assign o_status.top_zero = (w_top == 4'd0);
    assign o_status.one_left = (r_cnt == DIG_CW'(1));

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

endmodule

`default_nettype wire

// ===== hdl/bda_checker.sv =====
// ----------------------------------------------------------------------------
// bda_checker
// port level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bda_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire       o_valid,
    input wire [5:0] o_digit_char,
    input wire       o_last_digit
);

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= 6'd48) && (o_digit_char <= 6'd57))
        else $error("digit character out of range");

    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without busy");

    a_digits_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_digit) |=> o_valid)
        else $error("gap inside a digit run");

    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_digit) |-> busy)
        else $error("busy low before the last digit");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_valid && o_last_digit))
        else $error("busy dropped without the last digit");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_digit_char (o_digit_char),
    .o_last_digit (o_last_digit)
);

`default_nettype wire
